>>> rtl/core/rmed7_pkg.sv
// rmed7_pkg: shared types and constants of the running median filter
// used by the front, queue and back modules; no dependencies
`timescale 1ns / 1ps

package rmed7_pkg;

    // depth of the operation queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one window operation handed from front to back
    typedef struct packed {
        logic fill;   // load every window entry with the value
        logic emit;   // window median is a result
        logic last;   // final result of the buffer
    } rmed7_op_t;

endpackage

>>> rtl/core/rmed7_front.sv
// rmed7_front: accepts samples, tracks buffer position, expands each sample
// into window operations, with the flush sequence after end of buffer
// depends on rmed7_pkg
`timescale 1ns / 1ps

module rmed7_front #(
    parameter int HALF_WINDOW = 3,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_end_of_buffer,
    output logic                          push,
    output logic signed [SAMPLE_BITS-1:0] push_value,
    output rmed7_pkg::rmed7_op_t          push_op,
    input  logic                          q_full
);
    import rmed7_pkg::*;

    localparam int SW = $clog2(HALF_WINDOW + 1);

    logic [SW-1:0]                  seen_reg, seen_next;
    logic [SW-1:0]                  before_reg, before_next;
    logic [SW-1:0]                  step_reg, step_next;
    logic                           flush_reg, flush_next;
    logic signed [SAMPLE_BITS-1:0]  hold_reg, hold_next;
    logic                           take;
    logic                           flush_push;
    logic [SW:0]                    pos_sum;

    assign s_ready    = !flush_reg && !q_full;
    assign take       = s_valid && s_ready;
    assign flush_push = flush_reg && !q_full;
    assign pos_sum    = {1'b0, before_reg} + {1'b0, step_reg};

    always_comb begin
        seen_next   = seen_reg;
        before_next = before_reg;
        step_next   = step_reg;
        flush_next  = flush_reg;
        hold_next   = hold_reg;
        push        = 1'b0;
        push_value  = s_sample;
        push_op     = '{fill: 1'b0, emit: 1'b0, last: 1'b0};
        if (take) begin
            push         = 1'b1;
            push_op.fill = (seen_reg == '0);
            push_op.emit = (seen_reg >= SW'(HALF_WINDOW));
            if (seen_reg < SW'(HALF_WINDOW)) begin
                seen_next = seen_reg + SW'(1);
            end
            if (s_end_of_buffer) begin
                seen_next   = '0;
                flush_next  = 1'b1;
                step_next   = SW'(1);
                before_next = seen_reg;
                hold_next   = s_sample;
            end
        end else if (flush_push) begin
            push         = 1'b1;
            push_value   = hold_reg;
            push_op.emit = (pos_sum >= (SW + 1)'(HALF_WINDOW));
            push_op.last = (step_reg == SW'(HALF_WINDOW));
            if (step_reg == SW'(HALF_WINDOW)) begin
                flush_next = 1'b0;
            end else begin
                step_next = step_reg + SW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg  <= '0;
            flush_reg <= 1'b0;
        end else begin
            seen_reg  <= seen_next;
            flush_reg <= flush_next;
        end
        before_reg <= before_next;
        step_reg   <= step_next;
        hold_reg   <= hold_next;
    end

endmodule

>>> rtl/core/rmed7_queue.sv
// rmed7_queue: short register queue of window operations between front and back
// depends on rmed7_pkg
`timescale 1ns / 1ps

module rmed7_queue #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic signed [SAMPLE_BITS-1:0] push_value,
    input  rmed7_pkg::rmed7_op_t          push_op,
    output logic                          q_full,
    output logic                          q_valid,
    output logic signed [SAMPLE_BITS-1:0] q_value,
    output rmed7_pkg::rmed7_op_t          q_op,
    input  logic                          pop
);
    import rmed7_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic signed [SAMPLE_BITS-1:0] val_reg [QUEUE_DEPTH];
    rmed7_op_t                     op_reg  [QUEUE_DEPTH];
    logic [PW-1:0]                 wr_reg, wr_next;
    logic [PW-1:0]                 rd_reg, rd_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_value = val_reg[rd_reg];
    assign q_op    = op_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            val_reg[wr_reg] <= push_value;
            op_reg[wr_reg]  <= push_op;
        end
    end

endmodule

>>> rtl/core/rmed7_back.sv
// rmed7_back: applies window operations and sorts each emitted window in a
// pipelined odd-even transposition network; last stage is the output register
// depends on rmed7_pkg
`timescale 1ns / 1ps

module rmed7_back #(
    parameter int HALF_WINDOW = 3,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  logic signed [SAMPLE_BITS-1:0] q_value,
    input  rmed7_pkg::rmed7_op_t          q_op,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_filtered,
    output logic                          m_last_of_buffer
);
    import rmed7_pkg::*;

    localparam int N = 2 * HALF_WINDOW + 1;

    logic signed [SAMPLE_BITS-1:0] win_reg [N];
    logic signed [SAMPLE_BITS-1:0] win_next [N];
    logic signed [SAMPLE_BITS-1:0] stg_reg [N+1][N];
    logic signed [SAMPLE_BITS-1:0] srt [1:N][N];
    logic                          vld_reg [N+1];
    logic                          lst_reg [N+1];
    logic                          adv;

    assign adv              = !vld_reg[N] || m_ready;
    assign pop              = q_valid && adv;
    assign m_valid          = vld_reg[N];
    assign m_filtered       = stg_reg[N][HALF_WINDOW];
    assign m_last_of_buffer = lst_reg[N];

    // fill or shift the window
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (q_op.fill || i == N - 1) begin
                win_next[i] = q_value;
            end else begin
                win_next[i] = win_reg[i + 1];
            end
        end
    end

    // one compare-exchange round per stage
    always_comb begin
        for (int s = 1; s <= N; s++) begin
            srt[s] = stg_reg[s - 1];
            for (int i = (s - 1) % 2; i + 1 < N; i += 2) begin
                if (stg_reg[s - 1][i] > stg_reg[s - 1][i + 1]) begin
                    srt[s][i]     = stg_reg[s - 1][i + 1];
                    srt[s][i + 1] = stg_reg[s - 1][i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= N; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= pop && q_op.emit;
            for (int s = 1; s <= N; s++) begin
                vld_reg[s] <= vld_reg[s - 1];
            end
        end
        if (adv) begin
            stg_reg[0] <= win_next;
            lst_reg[0] <= q_op.last;
            for (int s = 1; s <= N; s++) begin
                stg_reg[s] <= srt[s];
                lst_reg[s] <= lst_reg[s - 1];
            end
        end
        if (pop) begin
            win_reg <= win_next;
        end
    end

endmodule

>>> rtl/core/running_median_of_seven.sv
// running_median_of_seven: 1-D running median, window 2*HALF_WINDOW+1
// result path: queue entry, window stage, then the sorting stages ending in the output register
// throughput: one sample per cycle while the queue is not full; after an end-of-buffer sample
// the input is held off while the front issues the flush operations
// reset: synchronous active-low aresetn empties queue and pipeline and starts a new buffer
// depends on rmed7_pkg, rmed7_front, rmed7_queue, rmed7_back
`timescale 1ns / 1ps

module running_median_of_seven #(
    parameter int HALF_WINDOW = 3,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_end_of_buffer,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_filtered,
    output logic                          m_last_of_buffer
);
    import rmed7_pkg::*;

    logic                          push;
    logic signed [SAMPLE_BITS-1:0] push_value;
    rmed7_op_t                     push_op;
    logic                          q_full;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] q_value;
    rmed7_op_t                     q_op;
    logic                          pop;

    rmed7_front #(
        .HALF_WINDOW (HALF_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .s_end_of_buffer (s_end_of_buffer),
        .push            (push),
        .push_value      (push_value),
        .push_op         (push_op),
        .q_full          (q_full)
    );

    rmed7_queue #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_value (push_value),
        .push_op    (push_op),
        .q_full     (q_full),
        .q_valid    (q_valid),
        .q_value    (q_value),
        .q_op       (q_op),
        .pop        (pop)
    );

    rmed7_back #(
        .HALF_WINDOW (HALF_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_value          (q_value),
        .q_op             (q_op),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered       (m_filtered),
        .m_last_of_buffer (m_last_of_buffer)
    );

endmodule

>>> rtl/core/rmed7_checker.sv
// rmed7_checker: port-level assertions for running_median_of_seven, bound to the top level
// depends on running_median_of_seven
`timescale 1ns / 1ps

module rmed7_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          s_end_of_buffer,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_filtered,
    input logic                          m_last_of_buffer
);

    // reset empties the result side
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // end-of-buffer transfer starts a flush, input held off next cycle
    a_flush_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_buffer |=> !s_ready)
        else $error("input taken during flush");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_filtered) && $stable(m_last_of_buffer))
        else $error("stalled result changed");

endmodule

bind running_median_of_seven rmed7_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_rmed7_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_end_of_buffer  (s_end_of_buffer),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_filtered       (m_filtered),
    .m_last_of_buffer (m_last_of_buffer)
);
